// File: rtl/multiplexed_led_pwm_scanner_defines.svh
// ----------------------------------------------------------------------------
// multiplexed_led_pwm_scanner_defines
// assertion macros used by the scanner checker
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_LED_PWM_SCANNER_DEFINES_SVH
`define MULTIPLEXED_LED_PWM_SCANNER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MLPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlps check failed");

// next-cycle implication, clocked on clk, off during reset
`define MLPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlps check failed");

`endif

// File: rtl/mlps_pkg.sv
// ----------------------------------------------------------------------------
// mlps_pkg
// constants and types of the multiplexed led pwm scanner
// ----------------------------------------------------------------------------
package mlps_pkg;

    localparam int NUM_LEDS    = 13;
    localparam int NUM_FRAMES  = 2;
    localparam int STORE_DEPTH = NUM_FRAMES * NUM_LEDS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int LEVEL_W  = 4;
    localparam int RELOAD_W = 8;
    localparam int LED_W    = 4;
    localparam int INDEX_W  = 5;
    localparam int REFILL_W = 2;
    localparam int HOLD_W   = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam logic [RELOAD_W-1:0] SKIP_RELOAD = RELOAD_W'(256 - 16);
    localparam logic [LEVEL_W-1:0]  FULL_LEVEL  = LEVEL_W'(15);
    localparam logic [RELOAD_W-1:0] PWM_STEPS   = RELOAD_W'(16);

    // input item kinds
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // refill request codes
    localparam logic [REFILL_W-1:0] REFILL_NONE  = 2'd0;
    localparam logic [REFILL_W-1:0] REFILL_LOWER = 2'd1;
    localparam logic [REFILL_W-1:0] REFILL_UPPER = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_HOLD_A = 1'b0;
    localparam logic REG_HOLD_B = 1'b1;

    typedef struct packed {
        logic [RELOAD_W-1:0] timer_reload;
        logic [LED_W-1:0]    led_select;
        logic                led_lit;
        logic [REFILL_W-1:0] refill_half;
    } mlps_result_t;

endpackage

// File: rtl/multiplexed_led_pwm_scanner.sv
// ----------------------------------------------------------------------------
// multiplexed_led_pwm_scanner
// one-led-at-a-time pwm scanner with a two-frame brightness store
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | mode, entry_index, brightness
//  out     | output    | out_valid/out_stall| timer_reload, led_select,
//          |           |                    | led_lit, refill_half
//  cfg     | apb slave | psel/penable/pready| hold_sweeps_frame_a/b
//
//  one transaction per cycle on the input while in_stall is low; a tick's
//  result is registered in the output register, or in the skid entry while
//  the output is held, a write gives no result
//  the state update is one short pass: one store read, a subtract, counters
//  output register plus one skid entry; in_stall rises only while the skid
//  entry holds a result, so input and output run at full rate together
//  rst_n clears control state and frame store, both hold registers return to 10
module multiplexed_led_pwm_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [mlps_pkg::INDEX_W-1:0]   entry_index,
    input  logic [mlps_pkg::LEVEL_W-1:0]   brightness,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mlps_pkg::RELOAD_W-1:0]  timer_reload,
    output logic [mlps_pkg::LED_W-1:0]     led_select,
    output logic                           led_lit,
    output logic [mlps_pkg::REFILL_W-1:0]  refill_half,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mlps_pkg::ADDR_W-1:0]    paddr,
    input  logic [mlps_pkg::DATA_W-1:0]    pwdata,
    output logic [mlps_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import mlps_pkg::*;

    // configuration registers
    logic [HOLD_W-1:0] hold_a_reg;
    logic [HOLD_W-1:0] hold_b_reg;
    logic              cfg_write;

    // scanner state
    logic [LEVEL_W-1:0]  store_reg [STORE_DEPTH];
    logic                off_pending_reg, off_pending_next;
    logic [RELOAD_W-1:0] off_reload_reg, off_reload_next;
    logic [LED_W-1:0]    led_pos_reg, led_pos_next;
    logic                frame_reg, frame_next;
    logic [HOLD_W-1:0]   hold_cnt_reg, hold_cnt_next;

    // output register and skid entry
    logic         out_valid_reg;
    mlps_result_t out_data_reg;
    logic         skid_valid_reg;
    mlps_result_t skid_data_reg;

    logic                in_accept;
    logic                tick;
    logic                store_wr;
    logic                out_fire;
    logic [STORE_AW-1:0] rd_addr;
    logic [LEVEL_W-1:0]  level;
    logic [LED_W:0]      led_inc;
    logic [HOLD_W-1:0]   hold_dec;
    mlps_result_t        res;

    // ------------------------------------------------------------------
    // apb register file, write on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_a_reg <= HOLD_W'(10);
            hold_b_reg <= HOLD_W'(10);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_HOLD_A)
            begin
                hold_a_reg <= pwdata[HOLD_W-1:0];
            end
            else
            begin
                hold_b_reg <= pwdata[HOLD_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_HOLD_A)
        begin
            prdata = DATA_W'(hold_a_reg);
        end
        else
        begin
            prdata = DATA_W'(hold_b_reg);
        end
    end

    // ------------------------------------------------------------------
    // handshake: stall only while the skid entry is taken
    // ------------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign tick      = in_accept && (mode == MODE_TICK);
    assign store_wr  = in_accept && (mode == MODE_WRITE)
                       && (entry_index < INDEX_W'(STORE_DEPTH));
    assign out_fire  = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // brightness store, 4-bit levels already saturated by the field width
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (store_wr)
        begin
            store_reg[entry_index[STORE_AW-1:0]] <= brightness;
        end
    end

    // entry of the current led in the frame on show
    assign rd_addr = frame_reg ? STORE_AW'(NUM_LEDS) + STORE_AW'(led_pos_reg)
                               : STORE_AW'(led_pos_reg);
    assign level   = store_reg[rd_addr];
    assign led_inc = {1'b0, led_pos_reg} + 1'b1;
    assign hold_dec = (hold_cnt_reg != '0) ? hold_cnt_reg - 1'b1 : hold_cnt_reg;

    // ------------------------------------------------------------------
    // one tick: on phase or skip, then the off phase that follows it
    // ------------------------------------------------------------------
    always_comb
    begin
        off_pending_next = off_pending_reg;
        off_reload_next  = off_reload_reg;
        led_pos_next     = led_pos_reg;
        frame_next       = frame_reg;
        hold_cnt_next    = hold_cnt_reg;
        res.timer_reload = off_reload_reg;
        res.led_select   = '0;
        res.led_lit      = 1'b0;
        res.refill_half  = REFILL_NONE;

        if (tick)
        begin
            if (!off_pending_reg)
            begin
                // off phase of the led just shown
                off_pending_next = 1'b1;
            end
            else
            begin
                if (level == '0)
                begin
                    res.timer_reload = SKIP_RELOAD;
                end
                else
                begin
                    res.timer_reload = RELOAD_W'(0) - RELOAD_W'(level);
                    off_reload_next  = RELOAD_W'(level) - PWM_STEPS;
                    res.led_select   = led_pos_reg;
                    res.led_lit      = 1'b1;
                end
                // full level keeps the led on, no off phase
                if ((level != '0) && (level != FULL_LEVEL))
                begin
                    off_pending_next = 1'b0;
                end

                if (led_inc >= (LED_W+1)'(NUM_LEDS))
                begin
                    // end of a sweep
                    led_pos_next  = '0;
                    hold_cnt_next = hold_dec;
                    if (hold_dec == '0)
                    begin
                        frame_next = ~frame_reg;
                        if (frame_reg)
                        begin
                            res.refill_half = REFILL_UPPER;
                            hold_cnt_next   = hold_a_reg;
                        end
                        else
                        begin
                            res.refill_half = REFILL_LOWER;
                            hold_cnt_next   = hold_b_reg;
                        end
                    end
                end
                else
                begin
                    led_pos_next = led_inc[LED_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_pending_reg <= 1'b0;
            off_reload_reg  <= '0;
            led_pos_reg     <= '0;
            frame_reg       <= 1'b0;
            hold_cnt_reg    <= '0;
        end
        else
        begin
            off_pending_reg <= off_pending_next;
            off_reload_reg  <= off_reload_next;
            led_pos_reg     <= led_pos_next;
            frame_reg       <= frame_next;
            hold_cnt_reg    <= hold_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // result register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no new transaction while the skid entry is full
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= tick;
        end
        else if (tick)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_data_reg <= res;
        end
        else if (tick)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign timer_reload = out_data_reg.timer_reload;
    assign led_select   = out_data_reg.led_select;
    assign led_lit      = out_data_reg.led_lit;
    assign refill_half  = out_data_reg.refill_half;

endmodule

// File: rtl/mlps_checker.sv
// ----------------------------------------------------------------------------
// mlps_checker
// port-level checks of the multiplexed led pwm scanner
// ----------------------------------------------------------------------------
`include "multiplexed_led_pwm_scanner_defines.svh"

module mlps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [mlps_pkg::RELOAD_W-1:0]  timer_reload,
    input logic [mlps_pkg::LED_W-1:0]     led_select,
    input logic                           led_lit,
    input logic [mlps_pkg::REFILL_W-1:0]  refill_half
);
    import mlps_pkg::*;

    // a held result stays offered
    `MLPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a held result keeps its payload
    `MLPS_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(timer_reload) && $stable(led_select) && $stable(led_lit)
        && $stable(refill_half))

    // input backs up only behind a full output register
    `MLPS_ASSERT_NOW(a_stall_full, in_stall, out_valid)

    // a dark result names no led
    `MLPS_ASSERT_NOW(a_dark_select, out_valid && !led_lit, led_select == '0)

endmodule

bind multiplexed_led_pwm_scanner mlps_checker u_mlps_checker (.*);
